// File: rtl/core/joystick_gimbal_command_mapper_top_defines.svh
// Assertion macros shared by the mapper's RTL files.
// Each macro expands to one labelled concurrent assertion, clocked on i_clk
// and switched off while i_rst_n is low.
`ifndef JOYSTICK_GIMBAL_COMMAND_MAPPER_TOP_DEFINES_SVH
`define JOYSTICK_GIMBAL_COMMAND_MAPPER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JGCM_ASSERT_SAME(name, ante, cons, text) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(text);

// Consequent must hold in the cycle after the antecedent.
`define JGCM_ASSERT_NEXT(name, ante, cons, text) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(text);

`endif

// File: rtl/core/jgcm_pkg.sv
package jgcm_pkg;

    localparam int AXIS_W = 16;
    localparam int DZ_W   = 15;
    localparam int RATE_W = 7;
    localparam int SPD_W  = 8;
    localparam int NUM_W  = AXIS_W + RATE_W;
    localparam int Q_W    = 8;
    localparam int CNT_W  = $clog2(Q_W);
    localparam int IDX_W  = 2;
    localparam int IN_W   = 56;
    localparam int OUT_W  = 32;

    localparam logic [IDX_W-1:0] CFG_DEADZONE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MOVE_SPEED = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ZOOM_RATE  = 2'd2;

    localparam logic [DZ_W-1:0]   DEADZONE_RST   = 15'd3277;
    localparam logic [RATE_W-1:0] MOVE_SPEED_RST = 7'd100;
    localparam logic [RATE_W-1:0] ZOOM_RATE_RST  = 7'd1;

    // Zone boundaries on the video axis (inclusive upper limits).
    localparam logic signed [AXIS_W-1:0] VID_LIM_IR_OFF  = -16'sd24576;
    localparam logic signed [AXIS_W-1:0] VID_LIM_VIS_OFF = -16'sd8192;
    localparam logic signed [AXIS_W-1:0] VID_LIM_NONE    = 16'sd8191;
    localparam logic signed [AXIS_W-1:0] VID_LIM_VIS_ON  = 16'sd24575;

    // Video zones double as the video command codes.
    typedef enum logic [2:0] {
        VID_NONE        = 3'd0,
        VID_VIS_PIP_OFF = 3'd1,
        VID_IR_PIP_OFF  = 3'd2,
        VID_VIS_PIP_ON  = 3'd3,
        VID_IR_PIP_ON   = 3'd4
    } t_vid_cmd;

    typedef struct packed {
        logic                     resync_video;
        logic                     thermal_selected;
        logic                     front_btn;
        logic                     home_button;
        logic                     zoom_out_btn;
        logic                     zoom_in_btn;
        logic signed [AXIS_W-1:0] video_raw;
        logic signed [AXIS_W-1:0] yaw_raw;
        logic signed [AXIS_W-1:0] pitch_raw;
        logic                     connected;
    } t_in_item;

    typedef struct packed {
        t_vid_cmd                video_command;
        logic                    ir_zoom_out_pulse;
        logic                    ir_zoom_in_pulse;
        logic                    go_front_pulse;
        logic                    go_home_pulse;
        logic signed [SPD_W-1:0] zoom_spd;
        logic signed [SPD_W-1:0] yaw_speed;
        logic signed [SPD_W-1:0] pitch_speed;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_load;
        logic div_sel_yaw;
        logic div_step;
        logic save_pitch;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/core/jgcm_div.sv
module jgcm_div (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_step,
    input  logic [jgcm_pkg::NUM_W-1:0] i_dividend,
    input  logic [jgcm_pkg::DZ_W-1:0]  i_divisor,
    output logic [jgcm_pkg::Q_W-1:0]   o_quotient
);

    // Restoring divider, one quotient bit per step. The caller guarantees the
    // quotient fits in Q_W bits, so the top bits of the dividend seed the
    // remainder directly.
    logic [jgcm_pkg::DZ_W-1:0] r_rem;
    logic [jgcm_pkg::Q_W-1:0]  r_quo;
    logic [jgcm_pkg::DZ_W:0]   trial;
    logic [jgcm_pkg::DZ_W:0]   diff;
    logic                      ge;

    always_comb begin
        trial = {r_rem, r_quo[jgcm_pkg::Q_W-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_dividend[jgcm_pkg::NUM_W-1:jgcm_pkg::Q_W];
            r_quo <= i_dividend[jgcm_pkg::Q_W-1:0];
        end else if (i_step) begin
            r_rem <= ge ? diff[jgcm_pkg::DZ_W-1:0] : trial[jgcm_pkg::DZ_W-1:0];
            r_quo <= {r_quo[jgcm_pkg::Q_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;

endmodule

// File: rtl/core/jgcm_dp.sv
module jgcm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [jgcm_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [jgcm_pkg::DZ_W-1:0]  i_cfg_wdata,
    input  logic [jgcm_pkg::IN_W-1:0]  i_in_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [jgcm_pkg::OUT_W-1:0] o_out_data,
    input  jgcm_pkg::t_dp_cmd          i_cmd,
    output jgcm_pkg::t_dp_stat         o_stat
);

    `include "joystick_gimbal_command_mapper_top_defines.svh"

    logic [jgcm_pkg::DZ_W-1:0]   r_deadzone;
    logic [jgcm_pkg::RATE_W-1:0] r_move_speed;
    logic [jgcm_pkg::RATE_W-1:0] r_zoom_rate;

    jgcm_pkg::t_in_item          r_in;
    logic [jgcm_pkg::NUM_W-1:0]  r_num_p;
    logic [jgcm_pkg::NUM_W-1:0]  r_num_y;
    logic                        r_act_p;
    logic                        r_act_y;
    logic [jgcm_pkg::Q_W-1:0]    r_q_p;

    logic                        r_active;
    logic                        r_zin_held;
    logic                        r_zout_held;
    logic                        r_home_held;
    logic                        r_front_held;
    jgcm_pkg::t_vid_cmd          r_zone;
    logic signed [jgcm_pkg::SPD_W-1:0] r_pitch;
    logic signed [jgcm_pkg::SPD_W-1:0] r_yaw;
    logic signed [jgcm_pkg::SPD_W-1:0] r_zoom;

    jgcm_pkg::t_out_item         r_out;
    logic                        r_out_valid;

    logic                        n_active;
    logic                        n_zin_held;
    logic                        n_zout_held;
    logic                        n_home_held;
    logic                        n_front_held;
    jgcm_pkg::t_vid_cmd          n_zone;
    logic signed [jgcm_pkg::SPD_W-1:0] n_pitch;
    logic signed [jgcm_pkg::SPD_W-1:0] n_yaw;
    logic signed [jgcm_pkg::SPD_W-1:0] n_zoom;
    jgcm_pkg::t_out_item         n_out;

    logic [jgcm_pkg::AXIS_W-1:0] abs_p;
    logic [jgcm_pkg::AXIS_W-1:0] abs_y;
    logic [jgcm_pkg::AXIS_W-1:0] diff_p;
    logic [jgcm_pkg::AXIS_W-1:0] diff_y;
    logic [jgcm_pkg::DZ_W-1:0]   den;
    logic [jgcm_pkg::Q_W-1:0]    q_y;
    jgcm_pkg::t_vid_cmd          zone_now;
    logic signed [jgcm_pkg::SPD_W-1:0] spd_p;
    logic signed [jgcm_pkg::SPD_W-1:0] spd_y;
    logic signed [jgcm_pkg::SPD_W-1:0] zoom_pos;

    function automatic logic signed [jgcm_pkg::SPD_W-1:0] axis_speed(
        input logic                        act,
        input logic                        neg,
        input logic [jgcm_pkg::Q_W-1:0]    q,
        input logic                        den_zero,
        input logic [jgcm_pkg::RATE_W-1:0] ms
    );
        logic [jgcm_pkg::RATE_W-1:0] mag;
        logic [jgcm_pkg::SPD_W-1:0]  ext;
        if (den_zero || (q > {1'b0, ms})) begin
            mag = ms;
        end else begin
            mag = q[jgcm_pkg::RATE_W-1:0];
        end
        ext = {1'b0, mag};
        if (!act) begin
            return '0;
        end else if (neg) begin
            return $signed(-ext);
        end else begin
            return $signed(ext);
        end
    endfunction

    // Deadzone scale denominator is 32767 - deadzone, i.e. the complement.
    assign den = ~r_deadzone;

    always_comb begin
        abs_p  = r_in.pitch_raw[jgcm_pkg::AXIS_W-1] ?
                 (~$unsigned(r_in.pitch_raw) + 16'd1) : $unsigned(r_in.pitch_raw);
        abs_y  = r_in.yaw_raw[jgcm_pkg::AXIS_W-1] ?
                 (~$unsigned(r_in.yaw_raw) + 16'd1) : $unsigned(r_in.yaw_raw);
        diff_p = abs_p - {1'b0, r_deadzone};
        diff_y = abs_y - {1'b0, r_deadzone};
    end

    jgcm_div u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (i_cmd.div_sel_yaw ? r_num_y : r_num_p),
        .i_divisor  (den),
        .o_quotient (q_y)
    );

    always_comb begin
        if (r_in.video_raw <= jgcm_pkg::VID_LIM_IR_OFF) begin
            zone_now = jgcm_pkg::VID_VIS_PIP_OFF;
        end else if (r_in.video_raw <= jgcm_pkg::VID_LIM_VIS_OFF) begin
            zone_now = jgcm_pkg::VID_IR_PIP_OFF;
        end else if (r_in.video_raw <= jgcm_pkg::VID_LIM_NONE) begin
            zone_now = jgcm_pkg::VID_NONE;
        end else if (r_in.video_raw <= jgcm_pkg::VID_LIM_VIS_ON) begin
            zone_now = jgcm_pkg::VID_VIS_PIP_ON;
        end else begin
            zone_now = jgcm_pkg::VID_IR_PIP_ON;
        end
    end

    always_comb begin
        spd_p    = axis_speed(r_act_p, r_in.pitch_raw[jgcm_pkg::AXIS_W-1], r_q_p,
                              (den == '0), r_move_speed);
        spd_y    = axis_speed(r_act_y, r_in.yaw_raw[jgcm_pkg::AXIS_W-1], q_y,
                              (den == '0), r_move_speed);
        zoom_pos = $signed({1'b0, r_zoom_rate});

        n_active     = r_active;
        n_zin_held   = r_zin_held;
        n_zout_held  = r_zout_held;
        n_home_held  = r_home_held;
        n_front_held = r_front_held;
        n_zone       = r_in.resync_video ? jgcm_pkg::VID_NONE : r_zone;
        n_pitch      = r_pitch;
        n_yaw        = r_yaw;
        n_zoom       = r_zoom;
        n_out        = '0;

        if (!r_in.connected) begin
            n_active    = 1'b0;
            n_zin_held  = 1'b0;
            n_zout_held = 1'b0;
        end else begin
            n_active = r_act_p | r_act_y | r_in.zoom_in_btn | r_in.zoom_out_btn;

            if (zone_now != n_zone) begin
                n_zone              = zone_now;
                n_out.video_command = zone_now;
            end

            n_out.go_home_pulse  = r_in.home_button & ~r_home_held;
            n_home_held          = r_in.home_button;
            n_out.go_front_pulse = r_in.front_btn & ~r_front_held;
            n_front_held         = r_in.front_btn;

            if (!n_active && r_active) begin
                n_pitch     = '0;
                n_yaw       = '0;
                n_zoom      = '0;
                n_zin_held  = 1'b0;
                n_zout_held = 1'b0;
            end else if (n_active) begin
                if (r_act_p || r_act_y) begin
                    n_pitch = spd_p;
                    n_yaw   = spd_y;
                end
                if (r_in.zoom_in_btn && !r_zin_held) begin
                    if (r_in.thermal_selected) begin
                        n_out.ir_zoom_in_pulse = 1'b1;
                    end else begin
                        n_zoom = zoom_pos;
                    end
                end else if (!r_in.zoom_in_btn && r_zin_held) begin
                    if (!r_in.thermal_selected && !r_in.zoom_out_btn) begin
                        n_zoom = '0;
                    end
                end
                n_zin_held = r_in.zoom_in_btn;
                if (r_in.zoom_out_btn && !r_zout_held) begin
                    if (r_in.thermal_selected) begin
                        n_out.ir_zoom_out_pulse = 1'b1;
                    end else begin
                        n_zoom = -zoom_pos;
                    end
                end else if (!r_in.zoom_out_btn && r_zout_held) begin
                    if (!r_in.thermal_selected && !r_in.zoom_in_btn) begin
                        n_zoom = '0;
                    end
                end
                n_zout_held = r_in.zoom_out_btn;
                // Zoom-in wins while both buttons are held and the thermal camera is not selected.
                if (r_in.zoom_in_btn && r_in.zoom_out_btn && !r_in.thermal_selected) begin
                    n_zoom = zoom_pos;
                end
            end
        end

        n_out.pitch_speed = n_pitch;
        n_out.yaw_speed   = n_yaw;
        n_out.zoom_spd    = n_zoom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone   <= jgcm_pkg::DEADZONE_RST;
            r_move_speed <= jgcm_pkg::MOVE_SPEED_RST;
            r_zoom_rate  <= jgcm_pkg::ZOOM_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jgcm_pkg::CFG_DEADZONE:   r_deadzone   <= i_cfg_wdata;
                jgcm_pkg::CFG_MOVE_SPEED: r_move_speed <= i_cfg_wdata[jgcm_pkg::RATE_W-1:0];
                jgcm_pkg::CFG_ZOOM_RATE:  r_zoom_rate  <= i_cfg_wdata[jgcm_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data[$bits(jgcm_pkg::t_in_item)-1:0];
        end
        if (i_cmd.mul) begin
            r_act_p <= (abs_p > {1'b0, r_deadzone});
            r_act_y <= (abs_y > {1'b0, r_deadzone});
            r_num_p <= jgcm_pkg::NUM_W'(diff_p) * jgcm_pkg::NUM_W'(r_move_speed);
            r_num_y <= jgcm_pkg::NUM_W'(diff_y) * jgcm_pkg::NUM_W'(r_move_speed);
        end
        if (i_cmd.save_pitch) begin
            r_q_p <= q_y;
        end
        if (i_cmd.update) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_zin_held   <= 1'b0;
            r_zout_held  <= 1'b0;
            r_home_held  <= 1'b0;
            r_front_held <= 1'b0;
            r_zone       <= jgcm_pkg::VID_NONE;
            r_pitch      <= '0;
            r_yaw        <= '0;
            r_zoom       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_active     <= n_active;
                r_zin_held   <= n_zin_held;
                r_zout_held  <= n_zout_held;
                r_home_held  <= n_home_held;
                r_front_held <= n_front_held;
                r_zone       <= n_zone;
                r_pitch      <= n_pitch;
                r_yaw        <= n_yaw;
                r_zoom       <= n_zoom;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = {1'b0, r_out};
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    `JGCM_ASSERT_NEXT(a_update_shows_result, i_cmd.update, r_out_valid,
                      "result not presented after update")
    `JGCM_ASSERT_NEXT(a_disconnect_no_video, i_cmd.update && !r_in.connected,
                      r_out.video_command == jgcm_pkg::VID_NONE,
                      "video command on a disconnected tick")

endmodule

// File: rtl/core/jgcm_ctrl.sv
module jgcm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jgcm_pkg::t_dp_stat i_stat,
    output jgcm_pkg::t_dp_cmd  o_cmd
);

    `include "joystick_gimbal_command_mapper_top_defines.svh"

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_LDP  = 7'b0000100,
        S_DIVP = 7'b0001000,
        S_LDY  = 7'b0010000,
        S_DIVY = 7'b0100000,
        S_UPD  = 7'b1000000
    } t_state;

    localparam logic [jgcm_pkg::CNT_W-1:0] CNT_LAST = jgcm_pkg::CNT_W'(jgcm_pkg::Q_W - 1);
    localparam logic [jgcm_pkg::CNT_W-1:0] CNT_ONE  = jgcm_pkg::CNT_W'(1);

    t_state                     r_state;
    t_state                     n_state;
    logic [jgcm_pkg::CNT_W-1:0] r_cnt;
    logic [jgcm_pkg::CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LDP;
            end
            S_LDP: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIVP;
            end
            S_DIVP: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_ONE;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_LDY;
                end
            end
            S_LDY: begin
                o_cmd.save_pitch  = 1'b1;
                o_cmd.div_load    = 1'b1;
                o_cmd.div_sel_yaw = 1'b1;
                n_cnt             = '0;
                n_state           = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.div_step    = 1'b1;
                o_cmd.div_sel_yaw = 1'b1;
                n_cnt             = r_cnt + CNT_ONE;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `JGCM_ASSERT_NEXT(a_accept_starts_work, i_in_valid && o_in_ready, r_state == S_MUL,
                      "accepted request did not start processing")
    `JGCM_ASSERT_NEXT(a_pitch_div_ends, r_state == S_DIVP && r_cnt == CNT_LAST,
                      r_state == S_LDY, "pitch division overran its step count")

endmodule

// File: rtl/core/joystick_gimbal_command_mapper_top.sv
// Joystick gimbal command mapper.
// One input request on the s_axis channel is one joystick poll tick; each
// request yields exactly one result request on the m_axis channel carrying
// the held pitch, yaw and zoom speeds, the button pulses and the video
// source/PIP command. The deadzone, move speed and zoom rate registers are
// written through the i_cfg port, one register per cycle; the user must
// write them only while the block is idle, which the block does not enforce.
// The pitch and yaw scaling share one restoring divider that takes 8 steps
// per axis. With the multiply, load and update states, a tick occupies the
// block until its update, so a new request is taken only after the previous
// tick has been updated.
// The input side is ready whenever the controller is idle, even while the
// previous result still waits in the output register. If the receiver
// stalls, the next tick is processed up to its update and then held until
// the output register is free; nothing is dropped or repeated.
// Reset (synchronous, active low) restores the register defaults, clears
// all held speeds and button flags and returns the video zone to neutral.
module joystick_gimbal_command_mapper_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port: index 0 deadzone, 1 move speed, 2 zoom rate.
    input  logic                       i_cfg_we,
    input  logic [jgcm_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [jgcm_pkg::DZ_W-1:0]  i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, from bit 0: connected, pitch_raw[15:0], yaw_raw[15:0],
    // video_raw[15:0], zoom in button, zoom out button, home_button,
    // front button, thermal_selected, resync_video, one unused pad bit.
    input  logic [jgcm_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata, from bit 0: pitch_speed[7:0], yaw_speed[7:0], zoom speed[7:0],
    // go_home_pulse, go_front_pulse, ir_zoom_in_pulse, ir_zoom_out_pulse,
    // video_command[2:0], one zero pad bit.
    output logic [jgcm_pkg::OUT_W-1:0] m_axis_tdata
);

    // Command and status between the sequencer and the datapath.
    jgcm_pkg::t_dp_cmd  dp_cmd;
    jgcm_pkg::t_dp_stat dp_stat;

    // The sequencer walks each tick through capture, multiply, the two
    // divisions and the state update.
    jgcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the configuration, the mapper state, the shared
    // divider and the output register.
    jgcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule
